// ===== sv/tssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssd_pkg
// Shared sizes, register indexes, sequencer states and small helper functions
// for the shadow denoise unit.
// ----------------------------------------------------------------------------
package tssd_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 4;

  localparam int RING_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int HIST_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int PIX_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DIM_W     = 9;
  localparam int RADF_W    = 3;
  localparam int HIST_AW   = $clog2(HIST_DEPTH);
  localparam int RING_AW   = $clog2(RING_DEPTH);
  localparam int POS_W     = $clog2(HIST_DEPTH + 1);
  localparam int X_W       = $clog2(MAX_WIDTH);
  localparam int Y_W       = $clog2(MAX_HEIGHT);
  localparam int EW_W      = $clog2(MAX_WIDTH + 1);
  localparam int EH_W      = $clog2(MAX_HEIGHT + 1);
  localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
  localparam int OFF_W     = RAD_W + 1;
  localparam int LAG_W     = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int N_MAX     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int N_W       = $clog2(N_MAX + 1);
  localparam int SUM_W     = $clog2(N_MAX * 65535 + N_MAX / 2 + 1);
  localparam int MOD_STEPS = $clog2((HIST_DEPTH + RING_DEPTH - 1) / RING_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_TEMPORAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_CHK, ST_HRD, ST_BLEND, ST_WR,
    ST_OCHK, ST_LIN, ST_RD, ST_ACC, ST_DIV, ST_WAIT, ST_OUT
  } state_t;

  // Reduce a raster position to its ring slot by restoring subtraction.
  function automatic logic [RING_AW-1:0] ring_mod(input logic [HIST_AW-1:0] lin);
    logic [HIST_AW:0] r;
    logic [HIST_AW:0] d;
    r = {1'b0, lin};
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      d = (HIST_AW + 1)'(RING_DEPTH) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return RING_AW'(r);
  endfunction

  // Sample count of a (2R+1) x (2R+1) box.
  function automatic logic [N_W-1:0] kernel_count(input logic [RAD_W-1:0] r);
    logic [N_W-1:0] d;
    d = N_W'({r, 1'b1});
    return N_W'(d * d);
  endfunction

endpackage

// ===== sv/temporal_spatial_shadow_denoise_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_spatial_shadow_denoise_unit
// Optional temporal history blend followed by a clamp-to-edge box blur over a ring of
// blended pixels, one item at a time under a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: a pixel item passes from acceptance through the start and check
//   states, the history read and blend when temporal blend is on, the ring write
//   and the output check back to idle (a drain item skips to the output check);
//   an item that releases a result adds a ring read per box sample (set by the
//   single ring read port), a bit-serial division and the output register load.
// Throughput: one item at a time; the next item is taken as soon as the
//   sequencer returns to idle, even while the last result waits in the output.
// Reset: a clearing pass writes zero to all 65536 history entries, during which
//   no item is taken; configuration writes work throughout.
// ----------------------------------------------------------------------------
module temporal_spatial_shadow_denoise_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic [tssd_pkg::PIX_W-1:0]     shadow_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tssd_pkg::PIX_W-1:0]     shadow_out,
  output logic                           frame_last,
  input  logic                           cfg_write,
  input  logic [tssd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tssd_pkg::CFG_W-1:0]     cfg_data
);
  import tssd_pkg::*;

  // Configuration registers
  logic              temporal_enable;
  logic [PIX_W-1:0]  blend_weight;
  logic [RADF_W-1:0] blur_radius;
  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;

  // Saturated geometry, refreshed every cycle
  logic [EW_W-1:0]  eff_w;
  logic [EH_W-1:0]  eff_h;
  logic [RAD_W-1:0] eff_r;
  logic [POS_W-1:0] total;
  logic [LAG_W-1:0] lag;
  logic [EW_W-1:0]  eff_w_next;
  logic [EH_W-1:0]  eff_h_next;
  logic [RAD_W-1:0] eff_r_next;

  state_t state, state_next;

  // Frame positions
  logic [POS_W-1:0]   in_pos;
  logic [POS_W-1:0]   out_pos;
  logic [RING_AW-1:0] ring_wp;
  logic [X_W-1:0]     ox;
  logic [Y_W-1:0]     oy;
  logic [HIST_AW-1:0] clr_addr;

  // Item and datapath registers
  logic                item_mode;
  logic [PIX_W-1:0]    item_pix;
  logic [PIX_W-1:0]    pix_v;
  logic [2*PIX_W-1:0]  prod;
  logic signed [OFF_W-1:0] dy;
  logic signed [OFF_W-1:0] dx;
  logic [HIST_AW-1:0]  lin;
  logic [SUM_W-1:0]    sum;
  logic [PIX_W-1:0]    box_q;

  // Memory ports
  logic [PIX_W-1:0] hist_rdata;
  logic [PIX_W-1:0] ring_rdata;
  logic             hist_we;
  logic [HIST_AW-1:0] hist_waddr;
  logic [PIX_W-1:0] hist_wdata;

  // Divider
  logic             div_start;
  logic             div_done;
  logic [PIX_W-1:0] div_q;
  logic [N_W-1:0]   kcount;

  // Combinational helpers
  logic                    in_take;
  logic                    out_free;
  logic                    pix_ok;
  logic                    restart;
  logic [POS_W-1:0]        need;
  logic [POS_W:0]          need_raw;
  logic [2*PIX_W:0]        blend_acc;
  logic signed [OFF_W-1:0] rad_s;
  logic signed [Y_W+1:0]   sy_s;
  logic signed [X_W+1:0]   sx_s;
  logic [Y_W-1:0]          sy;
  logic [X_W-1:0]          sx;
  logic [Y_W-1:0]          hm1;
  logic [X_W-1:0]          wm1;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign pix_ok   = (item_mode == 1'b0) && (in_pos < total);
  assign restart  = cfg_write && (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
                                  cfg_index == REG_HEIGHT);
  assign rad_s    = $signed({1'b0, eff_r});
  assign hm1      = Y_W'(eff_h - 1'b1);
  assign wm1      = X_W'(eff_w - 1'b1);
  assign kcount   = kernel_count(eff_r);

  // Configuration writes; geometry writes restart the frame below
  always_ff @(posedge clk) begin
    if (rst) begin
      temporal_enable <= 1'b0;
      blend_weight    <= '0;
      blur_radius     <= '0;
      frame_width     <= DIM_W'(MAX_WIDTH);
      frame_height    <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TEMPORAL: temporal_enable <= cfg_data[0];
        REG_WEIGHT:   blend_weight    <= cfg_data[PIX_W-1:0];
        REG_RADIUS:   blur_radius     <= cfg_data[RADF_W-1:0];
        REG_WIDTH:    frame_width     <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:   frame_height    <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the geometry: zero width or height counts as one, clip to the maximum
  always_comb begin
    if (frame_width == '0) begin
      eff_w_next = EW_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      eff_w_next = EW_W'(MAX_WIDTH);
    end else begin
      eff_w_next = EW_W'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h_next = EH_W'(1);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      eff_h_next = EH_W'(MAX_HEIGHT);
    end else begin
      eff_h_next = EH_W'(frame_height);
    end
    if (blur_radius > RADF_W'(MAX_RADIUS)) begin
      eff_r_next = RAD_W'(MAX_RADIUS);
    end else begin
      eff_r_next = RAD_W'(blur_radius);
    end
  end

  // Derived frame size and output lag, registered; the start state lies between acceptance and the check
  always_ff @(posedge clk) begin
    eff_w <= eff_w_next;
    eff_h <= eff_h_next;
    eff_r <= eff_r_next;
    total <= POS_W'(eff_w) * POS_W'(eff_h);
    lag   <= LAG_W'(eff_r) * LAG_W'(eff_w) + LAG_W'(eff_r);
  end

  // Earliest input count at which the next output has all its rows in the ring
  always_comb begin
    need_raw = {1'b0, out_pos} + (POS_W + 1)'(lag) + 1'b1;
    if (need_raw > {1'b0, total}) begin
      need = total;
    end else begin
      need = POS_W'(need_raw);
    end
  end

  // Clamp the current box sample to the frame edges
  always_comb begin
    sy_s = $signed({2'b00, oy}) + (Y_W + 2)'(dy);
    sx_s = $signed({2'b00, ox}) + (X_W + 2)'(dx);
    if (sy_s < 0) begin
      sy = '0;
    end else if (sy_s > $signed({2'b00, hm1})) begin
      sy = hm1;
    end else begin
      sy = Y_W'(sy_s);
    end
    if (sx_s < 0) begin
      sx = '0;
    end else if (sx_s > $signed({2'b00, wm1})) begin
      sx = wm1;
    end else begin
      sx = X_W'(sx_s);
    end
  end

  assign blend_acc = (2*PIX_W + 1)'(prod)
                   + (2*PIX_W + 1)'((2*PIX_W)'(item_pix)
                       * (2*PIX_W)'((PIX_W + 1)'(1 << PIX_W) - (PIX_W + 1)'(blend_weight)))
                   + (2*PIX_W + 1)'(1 << (PIX_W - 1));

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == HIST_AW'(HIST_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = ST_CHK;
      ST_CHK: begin
        if (pix_ok) begin
          state_next = temporal_enable ? ST_HRD : ST_WR;
        end else begin
          state_next = ST_OCHK;
        end
      end
      ST_HRD:   state_next = ST_BLEND;
      ST_BLEND: state_next = ST_WR;
      ST_WR:    state_next = ST_OCHK;
      ST_OCHK: begin
        if (out_pos < total && in_pos >= need) begin
          state_next = ST_LIN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LIN: state_next = ST_RD;
      ST_RD:  state_next = ST_ACC;
      ST_ACC: begin
        if (dx == rad_s && dy == rad_s) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_LIN;
        end
      end
      ST_DIV: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // History write: zero during the clearing pass, the blend afterwards
  always_comb begin
    hist_we    = (state == ST_CLEAR) || (state == ST_WR && temporal_enable);
    hist_waddr = (state == ST_CLEAR) ? clr_addr : in_pos[HIST_AW-1:0];
    hist_wdata = (state == ST_CLEAR) ? '0 : pix_v;
  end

  // Positions and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      in_pos   <= '0;
      out_pos  <= '0;
      ring_wp  <= '0;
      ox       <= '0;
      oy       <= '0;
      clr_addr <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (restart) begin
        in_pos  <= '0;
        out_pos <= '0;
        ring_wp <= '0;
        ox      <= '0;
        oy      <= '0;
      end else if (state == ST_WR) begin
        in_pos  <= in_pos + 1'b1;
        ring_wp <= (ring_wp == RING_AW'(RING_DEPTH - 1)) ? '0 : ring_wp + 1'b1;
      end else if (state == ST_OUT && out_free) begin
        // Advance the output raster; the last pixel ends the frame
        if (out_pos + 1'b1 >= total) begin
          in_pos  <= '0;
          out_pos <= '0;
          ring_wp <= '0;
          ox      <= '0;
          oy      <= '0;
        end else begin
          out_pos <= out_pos + 1'b1;
          if (ox == wm1) begin
            ox <= '0;
            oy <= oy + 1'b1;
          end else begin
            ox <= ox + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          item_mode <= mode;
          item_pix  <= shadow_in;
        end
      end
      ST_CHK:   pix_v <= item_pix;
      ST_HRD:   prod  <= hist_rdata * blend_weight;
      ST_BLEND: pix_v <= blend_acc[2*PIX_W-1:PIX_W];
      ST_OCHK: begin
        dy  <= -rad_s;
        dx  <= -rad_s;
        sum <= '0;
      end
      ST_LIN: lin <= HIST_AW'(sy) * HIST_AW'(eff_w) + HIST_AW'(sx);
      ST_ACC: begin
        sum <= sum + SUM_W'(ring_rdata);
        if (dx == rad_s) begin
          dx <= -rad_s;
          dy <= dy + 1'b1;
        end else begin
          dx <= dx + 1'b1;
        end
      end
      ST_WAIT: begin
        if (div_done) begin
          box_q <= div_q;
        end
      end
      default: ;
    endcase
  end

  // Output register: hold the result until taken, drop valid on handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      shadow_out <= box_q;
      frame_last <= (out_pos == total - 1'b1);
    end
  end

  tssd_ram #(
    .DEPTH(HIST_DEPTH),
    .WIDTH(PIX_W)
  ) u_history (
    .clk  (clk),
    .we   (hist_we),
    .waddr(hist_waddr),
    .wdata(hist_wdata),
    .re   (state == ST_CHK),
    .raddr(in_pos[HIST_AW-1:0]),
    .rdata(hist_rdata)
  );

  tssd_ram #(
    .DEPTH(RING_DEPTH),
    .WIDTH(PIX_W)
  ) u_ring (
    .clk  (clk),
    .we   (state == ST_WR),
    .waddr(ring_wp),
    .wdata(pix_v),
    .re   (state == ST_RD),
    .raddr(ring_mod(lin)),
    .rdata(ring_rdata)
  );

  tssd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum + SUM_W'(kcount >> 1)),
    .divisor (kcount),
    .done    (div_done),
    .quotient(div_q)
  );

endmodule

// ===== sv/tssd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssd_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tssd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tssd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssd_div
// Bit-serial restoring divider for the box average, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tssd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tssd_pkg::SUM_W-1:0] dividend,
  input  logic [tssd_pkg::N_W-1:0]   divisor,
  output logic                       done,
  output logic [tssd_pkg::PIX_W-1:0] quotient
);
  import tssd_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [N_W-1:0]   rem;
  logic [SUM_W-1:0] quo;
  logic [N_W-1:0]   dsr;
  logic [N_W:0]     trial;

  assign trial    = {rem, quo[SUM_W-1]};
  assign quotient = quo[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= N_W'(trial - {1'b0, dsr});
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[N_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule
